FILE: hw/rtl/sce_pkg.sv
// Shared types and constants for the SenML CBOR field encoder.
// Holds the command codes, the port structs, the byte descriptor and the label table.
// No dependencies.
package sce_pkg;

   localparam int COUNT_W   = 3;
   localparam int MAX_BYTES = 6;

   typedef enum logic [3:0] {
      CMD_START_PACK   = 4'd0,
      CMD_END_PACK     = 4'd1,
      CMD_START_RECORD = 4'd2,
      CMD_END_RECORD   = 4'd3,
      CMD_TEXT_HDR     = 4'd4,
      CMD_TEXT_BYTE    = 4'd5,
      CMD_INT          = 4'd6,
      CMD_FLOAT        = 4'd7,
      CMD_BOOL         = 4'd8
   } cmd_type;

   localparam logic [7:0] CBOR_ARRAY_START = 8'h9F;
   localparam logic [7:0] CBOR_MAP_START   = 8'hBF;
   localparam logic [7:0] CBOR_BREAK       = 8'hFF;
   localparam logic [7:0] CBOR_SIZE_1      = 8'h18;
   localparam logic [7:0] CBOR_SIZE_2      = 8'h19;
   localparam logic [7:0] CBOR_MAJOR_UINT  = 8'h00;
   localparam logic [7:0] CBOR_MAJOR_TEXT  = 8'h60;
   localparam logic [7:0] CBOR_FLOAT32     = 8'hFA;
   localparam logic [7:0] CBOR_FALSE       = 8'hF4;
   localparam logic [7:0] CBOR_TRUE        = 8'hF5;

   localparam logic [7:0] LABEL_MAP [15] = '{
      8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h20, 8'h00, 8'h01,
      8'h02, 8'h03, 8'h04, 8'h08, 8'h05, 8'h06, 8'h07
   };

   typedef struct packed {
      logic [3:0]  cmd;
      logic [3:0]  label_index;
      logic [30:0] int_value;
      logic [30:0] text_length;
      logic [7:0]  text_byte;
      logic [31:0] float_bits;
      logic        flag_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       too_large;
   } rsp_type;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [COUNT_W-1:0]        count;
      logic                      too_large;
   } desc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   function automatic logic [7:0] label_byte(input logic [3:0] idx);
      logic [3:0] sat;
      sat = (idx > 4'd14) ? 4'd14 : idx;
      return LABEL_MAP[sat];
   endfunction

endpackage

FILE: hw/rtl/sce_front.sv
// Front end: classifies one command into a descriptor of up to six CBOR bytes.
// Depends on sce_pkg.
module sce_front (
   input  sce_pkg::req_type  req_data,
   output sce_pkg::desc_type desc
);
   import sce_pkg::*;

   logic [7:0] label;

   function automatic desc_type sized_desc(input logic [7:0] lbl, input logic [7:0] major,
                                           input logic [30:0] v);
      desc_type d;
      d = '0;
      d.bytes[0] = lbl;
      if (|v[30:16]) begin
         d.count     = COUNT_W'(1);
         d.too_large = 1'b1;
      end else if (v[15:0] < 16'd24) begin
         d.bytes[1] = major | v[7:0];
         d.count    = COUNT_W'(2);
      end else if (v[15:8] == 8'd0) begin
         d.bytes[1] = major | CBOR_SIZE_1;
         d.bytes[2] = v[7:0];
         d.count    = COUNT_W'(3);
      end else begin
         d.bytes[1] = major | CBOR_SIZE_2;
         d.bytes[2] = v[15:8];
         d.bytes[3] = v[7:0];
         d.count    = COUNT_W'(4);
      end
      return d;
   endfunction

   assign label = label_byte(req_data.label_index);

   always_comb begin
      desc = '0;
      unique case (cmd_type'(req_data.cmd))
         CMD_START_PACK: begin
            desc.bytes[0] = CBOR_ARRAY_START;
            desc.count    = COUNT_W'(1);
         end
         CMD_END_PACK, CMD_END_RECORD: begin
            desc.bytes[0] = CBOR_BREAK;
            desc.count    = COUNT_W'(1);
         end
         CMD_START_RECORD: begin
            desc.bytes[0] = CBOR_MAP_START;
            desc.count    = COUNT_W'(1);
         end
         CMD_TEXT_HDR: begin
            desc = sized_desc(label, CBOR_MAJOR_TEXT, req_data.text_length);
         end
         CMD_TEXT_BYTE: begin
            desc.bytes[0] = req_data.text_byte;
            desc.count    = COUNT_W'(1);
         end
         CMD_INT: begin
            desc = sized_desc(label, CBOR_MAJOR_UINT, req_data.int_value);
         end
         CMD_FLOAT: begin
            desc.bytes[0] = label;
            desc.bytes[1] = CBOR_FLOAT32;
            desc.bytes[2] = req_data.float_bits[31:24];
            desc.bytes[3] = req_data.float_bits[23:16];
            desc.bytes[4] = req_data.float_bits[15:8];
            desc.bytes[5] = req_data.float_bits[7:0];
            desc.count    = COUNT_W'(6);
         end
         CMD_BOOL: begin
            desc.bytes[0] = label;
            desc.bytes[1] = req_data.flag_value ? CBOR_TRUE : CBOR_FALSE;
            desc.count    = COUNT_W'(2);
         end
         default: begin
            desc = '0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/sce_queue.sv
// Descriptor queue between the front end and the byte serializer.
// Depends on sce_pkg.
module sce_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sce_pkg::desc_type  wr_desc,
   input  logic               pop,
   output sce_pkg::desc_type  head,
   output sce_pkg::qstat_type stat
);
   import sce_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);

   desc_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]   level_ff,  level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + LVL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_desc;
      end
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.empty = (level_ff == '0);
   assign stat.full  = (level_ff == LVL_W'(DEPTH));

endmodule

FILE: hw/rtl/sce_back.sv
// Back end: serializes queued descriptors into one registered CBOR byte per cycle.
// Depends on sce_pkg.
module sce_back (
   input  logic               clock,
   input  logic               reset,
   input  sce_pkg::desc_type  head,
   input  sce_pkg::qstat_type stat,
   output logic               pop,
   output logic               rsp_strobe,
   output sce_pkg::rsp_type   rsp_data
);
   import sce_pkg::*;

   logic [MAX_BYTES-1:0][7:0] bytes_ff, bytes_in;
   logic [COUNT_W-1:0]        remain_ff, remain_in;
   logic                      big_ff, big_in;
   logic                      rsp_strobe_ff;
   rsp_type                   rsp_data_ff;

   assign pop = (remain_ff <= COUNT_W'(1)) && !stat.empty;

   always_comb begin
      bytes_in  = bytes_ff;
      remain_in = remain_ff;
      big_in    = big_ff;
      if (pop) begin
         bytes_in  = head.bytes;
         remain_in = head.count;
         big_in    = head.too_large;
      end else if (remain_ff != '0) begin
         bytes_in  = {8'h00, bytes_ff[MAX_BYTES-1:1]};
         remain_in = remain_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         remain_ff     <= remain_in;
         rsp_strobe_ff <= (remain_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff              <= bytes_in;
      big_ff                <= big_in;
      rsp_data_ff.out_byte  <= bytes_ff[0];
      rsp_data_ff.last      <= (remain_ff == COUNT_W'(1));
      rsp_data_ff.too_large <= big_ff;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

FILE: hw/rtl/senml_cbor_field_encoder.sv
// SenML CBOR field encoder top level: front end, descriptor queue, byte serializer.
// Depends on sce_pkg, sce_front, sce_queue, sce_back.
//
// A command is taken when start is high and busy is low; commands are taken
// back to back as long as the queue of QUEUE_DEPTH pending commands has room.
// Each command then yields as many bytes on the one-byte result port as it
// encodes to: one for start, end and text byte commands, two for bool, up to
// four for int and text header, six for float, none for unknown codes. The
// sustained rate is therefore set by the output byte rate of the serializer,
// one byte per cycle. Results appear on rsp_data for one cycle with rsp_strobe
// high, the first byte after the queue, the serializer byte register and the
// output register; the receiver must take every byte as it comes.
module senml_cbor_field_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sce_pkg::req_type req_data,
   output logic             rsp_strobe,
   output sce_pkg::rsp_type rsp_data
);
   import sce_pkg::*;

   desc_type  front_desc;
   desc_type  head;
   qstat_type q_stat;
   logic      push;
   logic      pop;

   sce_front u_front (
      .req_data (req_data),
      .desc     (front_desc)
   );

   assign busy = q_stat.full;
   assign push = start && !busy && (front_desc.count != '0);

   sce_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_desc (front_desc),
      .pop     (pop),
      .head    (head),
      .stat    (q_stat)
   );

   sce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .stat       (q_stat),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   a_too_large_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.too_large |-> rsp_data.last)
      else $error("too_large set on a byte that does not end its transaction");

   a_no_gap_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe)
      else $error("gap inside an encoded transaction");

   a_push_fills_queue: assert property (@(posedge clock) disable iff (reset)
      push |=> !q_stat.empty)
      else $error("accepted transaction lost from the queue");

endmodule
